// ----- rtl/sacht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacht_pkg
// Shared types and constants for the set-associative cache hit tracker.
// ----------------------------------------------------------------------------
package sacht_pkg;

    // default geometry
    localparam int DEF_SETS         = 64;
    localparam int DEF_WAYS         = 4;
    localparam int DEF_ADDRESS_BITS = 32;

    // configuration register widths
    localparam int OFFSET_W = 5;
    localparam int INDEX_W  = 3;
    localparam int WAYSU_W  = 3;
    localparam int POLICY_W = 1;

    // bus widths
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int COUNT_W = 32;

    // configuration reset values
    localparam logic [OFFSET_W-1:0] RST_OFFSET_BITS    = 5'd5;
    localparam logic [INDEX_W-1:0]  RST_INDEX_BITS     = 3'd0;
    localparam logic [WAYSU_W-1:0]  RST_WAYS_USED      = 3'd2;
    localparam logic [POLICY_W-1:0] RST_REPLACE_POLICY = 1'b1;

    localparam logic [POLICY_W-1:0] POLICY_FIFO = 1'b0;
    localparam logic [POLICY_W-1:0] POLICY_LRU  = 1'b1;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_OFFSET_BITS    = 2'd0,
        REG_INDEX_BITS     = 2'd1,
        REG_WAYS_USED      = 2'd2,
        REG_REPLACE_POLICY = 2'd3
    } cfg_reg_t;

endpackage

// ----- rtl/set_associative_cache_hit_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_associative_cache_hit_tracker
// Tag lookup with FIFO or LRU replacement, hit/evict flags, request and
// hit counters.
//
// Usage:
//   The request channel (req_valid/req_ready) carries one byte address per
//   transaction. The response channel (rsp_valid/rsp_ready) returns hit,
//   evicted and the saturating request and hit totals for that address.
//   Geometry (offset bits, index bits, ways in use, policy) is set through
//   the APB port; the user must write it only while the block is idle,
//   which the block itself does not enforce.
//   Flow: the set's tag and meta rows are read from RAM when a request is
//   accepted and written back in the lookup state, before the next request
//   may read; a new request is taken only after the last one's lookup ends.
//   Reset: after rst_n is released the meta RAM (valid bits, age ranks)
//   is cleared one set per cycle, through all SETS sets, with req_ready low;
//   APB writes are taken during that time. Counters reset to zero.
//   Stall: the response is held in an output register; one more request
//   is accepted while it waits, and its lookup then holds until the
//   output register frees up.
// ----------------------------------------------------------------------------
module set_associative_cache_hit_tracker
    import sacht_pkg::*;
#(
    parameter int SETS         = DEF_SETS,
    parameter int WAYS         = DEF_WAYS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // APB configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    // request channel
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [ADDRESS_BITS-1:0] address,
    // response channel
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic                    hit,
    output logic                    evicted,
    output logic [COUNT_W-1:0]      request_total,
    output logic [COUNT_W-1:0]      hit_total
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int MAX_IB = $clog2(SETS + 1) - 1;   // floor(log2 SETS)
    localparam int META_E = 1 + RANK_W;             // {valid, rank} per way
    localparam int META_W = WAYS * META_E;
    localparam int TAG_RW = WAYS * ADDRESS_BITS;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
    localparam logic [SET_W-1:0]  LAST_SET = SET_W'(SETS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [OFFSET_W-1:0] offset_bits_reg;
    logic [INDEX_W-1:0]  index_bits_reg;
    logic [WAYSU_W-1:0]  ways_used_reg;
    logic [POLICY_W-1:0] replace_policy_reg;
    logic                cfg_we;
    cfg_reg_t            cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg    <= RST_OFFSET_BITS;
            index_bits_reg     <= RST_INDEX_BITS;
            ways_used_reg      <= RST_WAYS_USED;
            replace_policy_reg <= RST_REPLACE_POLICY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                REG_OFFSET_BITS:    offset_bits_reg    <= pwdata[OFFSET_W-1:0];
                REG_INDEX_BITS:     index_bits_reg     <= pwdata[INDEX_W-1:0];
                REG_WAYS_USED:      ways_used_reg      <= pwdata[WAYSU_W-1:0];
                REG_REPLACE_POLICY: replace_policy_reg <= pwdata[POLICY_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_OFFSET_BITS:    prdata = PDATA_W'(offset_bits_reg);
            REG_INDEX_BITS:     prdata = PDATA_W'(index_bits_reg);
            REG_WAYS_USED:      prdata = PDATA_W'(ways_used_reg);
            REG_REPLACE_POLICY: prdata = PDATA_W'(replace_policy_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // address split (request side, combinational)
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0]      ib_eff;
    logic [OFFSET_W:0]       tag_shift;
    logic [ADDRESS_BITS-1:0] addr_shifted;
    logic [SET_W-1:0]        set_mask;
    logic [SET_W-1:0]        req_set;
    logic [ADDRESS_BITS-1:0] req_tag;

    always_comb
    begin
        ib_eff = (int'(index_bits_reg) > MAX_IB) ? INDEX_W'(MAX_IB) : index_bits_reg;
        for (int i = 0; i < SET_W; i++)
        begin
            set_mask[i] = (i < int'(ib_eff));
        end
        addr_shifted = address >> offset_bits_reg;
        // index below 2**MAX_IB <= SETS, so no wrap is needed
        req_set   = addr_shifted[SET_W-1:0] & set_mask;
        tag_shift = {1'b0, offset_bits_reg} + (OFFSET_W + 1)'(ib_eff);
        req_tag   = address >> tag_shift;
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [SET_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [SET_W-1:0]        set_reg, set_next;
    logic [ADDRESS_BITS-1:0] tag_reg, tag_next;
    logic [COUNT_W-1:0]      req_cnt_reg, req_cnt_next;
    logic [COUNT_W-1:0]      hit_cnt_reg, hit_cnt_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    hit_reg, hit_next;
    logic                    evicted_reg, evicted_next;

    logic req_fire;
    logic out_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    logic              tag_we, meta_we;
    logic [SET_W-1:0]  meta_waddr;
    logic [TAG_RW-1:0] tag_rdata, tag_wdata;
    logic [META_W-1:0] meta_rdata, meta_wdata, meta_upd;

    sacht_ram #(
        .WIDTH (TAG_RW),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (set_reg),
        .wdata (tag_wdata),
        .re    (req_fire),
        .raddr (req_set),
        .rdata (tag_rdata)
    );

    sacht_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (req_fire),
        .raddr (req_set),
        .rdata (meta_rdata)
    );

    // ------------------------------------------------------------------
    // lookup and replacement on the row read back
    // ------------------------------------------------------------------
    logic [ADDRESS_BITS-1:0] tag_rd   [WAYS];
    logic                    vld_rd   [WAYS];
    logic [RANK_W-1:0]       rank_rd  [WAYS];
    logic                    vld_wr   [WAYS];
    logic [RANK_W-1:0]       rank_wr  [WAYS];
    logic [WAYS-1:0]         way_on;
    logic [WAYSU_W-1:0]      ways_eff;
    logic                    lk_hit, free_found, victim_found;
    logic [WAY_W-1:0]        hit_way, free_way, victim_way, fill_way;

    always_comb
    begin
        if (ways_used_reg == '0)
        begin
            ways_eff = WAYSU_W'(1);
        end
        else if (int'(ways_used_reg) > WAYS)
        begin
            ways_eff = WAYSU_W'(WAYS);
        end
        else
        begin
            ways_eff = ways_used_reg;
        end

        for (int w = 0; w < WAYS; w++)
        begin
            way_on[w]  = (w < int'(ways_eff));
            tag_rd[w]  = tag_rdata[w*ADDRESS_BITS +: ADDRESS_BITS];
            vld_rd[w]  = meta_rdata[w*META_E + RANK_W];
            rank_rd[w] = meta_rdata[w*META_E +: RANK_W];
        end

        lk_hit       = 1'b0;
        hit_way      = '0;
        free_found   = 1'b0;
        free_way     = '0;
        victim_found = 1'b0;
        victim_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!lk_hit && way_on[w] && vld_rd[w] && tag_rd[w] == tag_reg)
            begin
                lk_hit  = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (way_on[w])
            begin
                if (!vld_rd[w])
                begin
                    if (!free_found)
                    begin
                        free_found = 1'b1;
                        free_way   = WAY_W'(w);
                    end
                end
                else if (!victim_found || rank_rd[w] > rank_rd[victim_way])
                begin
                    victim_found = 1'b1;
                    victim_way   = WAY_W'(w);
                end
            end
        end

        fill_way = free_found ? free_way : victim_way;

        for (int w = 0; w < WAYS; w++)
        begin
            vld_wr[w]  = vld_rd[w];
            rank_wr[w] = rank_rd[w];
            if (lk_hit)
            begin
                if (replace_policy_reg == POLICY_LRU)
                begin
                    if (WAY_W'(w) == hit_way)
                    begin
                        rank_wr[w] = '0;
                    end
                    else if (way_on[w] && vld_rd[w] && rank_rd[w] < rank_rd[hit_way]
                             && rank_rd[w] != RANK_MAX)
                    begin
                        rank_wr[w] = rank_rd[w] + RANK_W'(1);
                    end
                end
            end
            else
            begin
                if (WAY_W'(w) == fill_way)
                begin
                    vld_wr[w]  = 1'b1;
                    rank_wr[w] = '0;
                end
                else if (way_on[w] && vld_rd[w] && rank_rd[w] != RANK_MAX)
                begin
                    rank_wr[w] = rank_rd[w] + RANK_W'(1);
                end
            end
        end

        for (int w = 0; w < WAYS; w++)
        begin
            meta_upd[w*META_E +: META_E] = {vld_wr[w], rank_wr[w]};
            tag_wdata[w*ADDRESS_BITS +: ADDRESS_BITS] =
                (WAY_W'(w) == fill_way) ? tag_reg : tag_rd[w];
        end
    end

    logic lookup_done;
    assign lookup_done = (state_reg == ST_LOOKUP) && out_free;

    assign tag_we     = lookup_done && !lk_hit;
    assign meta_we    = (state_reg == ST_CLEAR) || lookup_done;
    assign meta_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
    assign meta_wdata = (state_reg == ST_CLEAR) ? '0 : meta_upd;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        set_next       = set_reg;
        tag_next       = tag_reg;
        req_cnt_next   = req_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        hit_next       = hit_reg;
        evicted_next   = evicted_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == LAST_SET)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    set_next   = req_set;
                    tag_next   = req_tag;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    req_cnt_next   = (req_cnt_reg == COUNT_MAX) ? req_cnt_reg
                                                                : req_cnt_reg + COUNT_W'(1);
                    hit_cnt_next   = (!lk_hit || hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg
                                                                 : hit_cnt_reg + COUNT_W'(1);
                    rsp_valid_next = 1'b1;
                    hit_next       = lk_hit;
                    evicted_next   = !lk_hit && !free_found;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            set_reg       <= '0;
            tag_reg       <= '0;
            req_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            evicted_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            set_reg       <= set_next;
            tag_reg       <= tag_next;
            req_cnt_reg   <= req_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            hit_reg       <= hit_next;
            evicted_reg   <= evicted_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign hit           = hit_reg;
    assign evicted       = evicted_reg;
    assign request_total = req_cnt_reg;
    assign hit_total     = hit_cnt_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_hit_le_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (hit_total <= request_total))
        else $error("hit total exceeds request total");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(hit && evicted))
        else $error("hit reported together with eviction");

    a_fire_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_LOOKUP) && !req_ready)
        else $error("accepted request did not enter lookup");

    a_lookup_resp: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_done |=> rsp_valid && (state_reg == ST_IDLE))
        else $error("lookup finished without a response");

    a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !tag_we && !req_ready)
        else $error("tag write or request accepted during clear");

endmodule

// ----- rtl/sacht_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacht_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sacht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
